[src/chcte_pkg.sv]
// Shared types, constants and helpers of the chart column trace extractor.
package chcte_pkg;

	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int HGT_W      = 13;
	localparam int RECIP_W    = 33;
	localparam int NORM_W     = 17;
	localparam int PROD_W     = HGT_W + RECIP_W;
	localparam int Q_SHIFT    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = RECIP_W;
	localparam int PIX_W      = 24;
	localparam int OUT_DATA_W = 4 * HGT_W + 4 * NORM_W;
	localparam int OUT_USER_W = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [9:0] DARK_START = 10'd765;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_HEIGHT   = 3'd0,
		REG_HEIGHT_RECIP   = 3'd1,
		REG_MARKER_RED     = 3'd2,
		REG_MARKER_GREEN   = 3'd3,
		REG_MARKER_BLUE    = 3'd4
	} cfg_reg_t;

	// One finished column, handed from the front to the back.
	typedef struct packed {
		logic [HGT_W-1:0] gust;
		logic [HGT_W-1:0] speed;
		logic [HGT_W-1:0] dir;
		logic [HGT_W-1:0] prev;
		logic             first;
		logic             seen;
		logic             multiple;
		logic             wrap;
	} col_rec_t;

	// Status of the column queue as seen by its neighbors.
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

	// Clamp the height register into 1..MAX_HEIGHT.
	function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] h);
		logic [HGT_W-1:0] r;
		begin
			if (h == '0) begin
				r = HGT_W'(1);
			end else if (h > HGT_W'(MAX_HEIGHT)) begin
				r = HGT_W'(MAX_HEIGHT);
			end else begin
				r = h;
			end
			return r;
		end
	endfunction

endpackage

[src/chcte_queue.sv]
// Short queue of finished column records between the front and the back.
module chcte_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  chcte_pkg::col_rec_t push_rec,
	input  logic               pop,
	output chcte_pkg::col_rec_t pop_rec,
	output chcte_pkg::q_stat_t  stat
);
	import chcte_pkg::*;

	col_rec_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	logic do_push;
	logic do_pop;

	assign stat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.valid = (count_q != '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & stat.valid;
	assign pop_rec    = mem_q[rd_ptr_q];

	// Record storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

[src/chcte_front.sv]
// Pixel front end: per-column tracking of pink, dark and marker rows.
module chcte_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [chcte_pkg::PIX_W-1:0]   s_tdata,  // red, green, blue
	input  logic [0:0]                    s_tuser,  // image_start
	input  logic [chcte_pkg::HGT_W-1:0]   height,
	input  logic [7:0]                    marker_red,
	input  logic [7:0]                    marker_green,
	input  logic [7:0]                    marker_blue,
	input  chcte_pkg::q_stat_t            q_stat,
	output logic                          col_push,
	output chcte_pkg::col_rec_t           col_rec
);
	import chcte_pkg::*;

	logic [ROW_W-1:0] row_count_q;
	logic [8:0]       best_pink_q;
	logic [ROW_W-1:0] best_pink_row_q;
	logic [9:0]       least_dark_q;
	logic [ROW_W-1:0] least_dark_row_q;
	logic [ROW_W-1:0] marker_row_q;
	logic             marker_seen_q;
	logic             marker_multiple_q;
	logic [HGT_W-1:0] prev_dir_q;
	logic             first_column_q;

	logic [7:0]       red, green, blue;
	logic             take, start;
	logic [ROW_W-1:0] row_cur, prow_cur, drow_cur, mrow_cur;
	logic [8:0]       pink_cur;
	logic [9:0]       dark_cur;
	logic             seen_cur, mult_cur, first_cur;
	logic [HGT_W-1:0] prev_cur;
	logic [8:0]       diff;
	logic [9:0]       sum;
	logic             pink_hit, dark_hit, marker_hit;
	logic [8:0]       pink_new;
	logic [9:0]       dark_new;
	logic [ROW_W-1:0] prow_new, drow_new, mrow_new;
	logic             seen_new, mult_new;
	logic             col_end;

	assign red      = s_tdata[7:0];
	assign green    = s_tdata[15:8];
	assign blue     = s_tdata[23:16];
	assign start    = s_tuser[0];
	assign s_tready = ~q_stat.full;
	assign take     = s_tvalid & s_tready;

	// An image start clears the column history before the pixel is used.
	assign row_cur   = start ? '0 : row_count_q;
	assign pink_cur  = start ? '0 : best_pink_q;
	assign prow_cur  = start ? '0 : best_pink_row_q;
	assign dark_cur  = start ? DARK_START : least_dark_q;
	assign drow_cur  = start ? '0 : least_dark_row_q;
	assign mrow_cur  = start ? '0 : marker_row_q;
	assign seen_cur  = start ? 1'b0 : marker_seen_q;
	assign mult_cur  = start ? 1'b0 : marker_multiple_q;
	assign prev_cur  = start ? '0 : prev_dir_q;
	assign first_cur = start ? 1'b1 : first_column_q;

	// Compare the pixel against the running extremes and the marker colour.
	assign diff       = {1'b0, red} - {1'b0, green};
	assign sum        = {2'b0, red} + {2'b0, green} + {2'b0, blue};
	assign pink_hit   = (red > green) && (diff > pink_cur);
	assign dark_hit   = (sum < dark_cur);
	assign marker_hit = (red == marker_red) && (green == marker_green) &&
	                    (blue == marker_blue);

	assign pink_new = pink_hit ? diff : pink_cur;
	assign prow_new = pink_hit ? row_cur : prow_cur;
	assign dark_new = dark_hit ? sum : dark_cur;
	assign drow_new = dark_hit ? row_cur : drow_cur;
	assign mrow_new = marker_hit ? row_cur : mrow_cur;
	assign seen_new = seen_cur | marker_hit;
	assign mult_new = mult_cur | (marker_hit & seen_cur);

	assign col_end = (({1'b0, row_cur} + HGT_W'(1)) >= height);

	// Column result; heights wrap to the field width.
	assign col_rec.gust     = height - {1'b0, prow_new};
	assign col_rec.speed    = height - {1'b0, drow_new};
	assign col_rec.dir      = seen_new ? (height - {1'b0, mrow_new}) : prev_cur;
	assign col_rec.prev     = prev_cur;
	assign col_rec.first    = first_cur;
	assign col_rec.seen     = seen_new;
	assign col_rec.multiple = mult_new;
	// The marker sits below a lowered height, so its direction went below zero.
	assign col_rec.wrap     = seen_new && ({1'b0, mrow_new} > height);
	assign col_push         = take & col_end;

	// Tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q       <= '0;
			best_pink_q       <= '0;
			best_pink_row_q   <= '0;
			least_dark_q      <= DARK_START;
			least_dark_row_q  <= '0;
			marker_row_q      <= '0;
			marker_seen_q     <= 1'b0;
			marker_multiple_q <= 1'b0;
			prev_dir_q        <= '0;
			first_column_q    <= 1'b1;
		end else if (take) begin
			if (col_end) begin
				row_count_q       <= '0;
				best_pink_q       <= '0;
				best_pink_row_q   <= '0;
				least_dark_q      <= DARK_START;
				least_dark_row_q  <= '0;
				marker_row_q      <= '0;
				marker_seen_q     <= 1'b0;
				marker_multiple_q <= 1'b0;
				prev_dir_q        <= col_rec.dir;
				first_column_q    <= 1'b0;
			end else begin
				row_count_q       <= row_cur + ROW_W'(1);
				best_pink_q       <= pink_new;
				best_pink_row_q   <= prow_new;
				least_dark_q      <= dark_new;
				least_dark_row_q  <= drow_new;
				marker_row_q      <= mrow_new;
				marker_seen_q     <= seen_new;
				marker_multiple_q <= mult_new;
				prev_dir_q        <= prev_cur;
				first_column_q    <= first_cur;
			end
		end
	end

endmodule

[src/chcte_back.sv]
// Result back end: direction change, Q16 normalization and output register.
module chcte_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  chcte_pkg::q_stat_t               q_stat,
	input  chcte_pkg::col_rec_t              q_rec,
	output logic                             q_pop,
	input  logic [chcte_pkg::HGT_W-1:0]      height,
	input  logic [chcte_pkg::RECIP_W-1:0]    recip,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [chcte_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [chcte_pkg::OUT_USER_W-1:0] m_tuser
);
	import chcte_pkg::*;

	logic rdy_s1, rdy_s2, rdy_s3;
	logic v_s1, v_s2, v_s3;

	logic [HGT_W-1:0] gust_s1, speed_s1, dir_s1, change_s1;
	logic [2:0]       flags_s1;
	logic [HGT_W-1:0] gust_s2, speed_s2, dir_s2, change_s2;
	logic [2:0]       flags_s2;
	logic [PROD_W-1:0] gust_p_s2, speed_p_s2, dir_p_s2, change_p_s2;
	logic [OUT_DATA_W-1:0] data_s3;
	logic [OUT_USER_W-1:0] user_s3;

	logic signed [HGT_W+1:0] d_minus_p, up_d, down_d;
	logic [HGT_W+1:0]        abs_a, abs_u, abs_d, best;
	logic [HGT_W-1:0]        change;

	// Stall chain: each stage moves when the one after it can take data.
	assign rdy_s3 = ~v_s3 | m_tready;
	assign rdy_s2 = ~v_s2 | rdy_s3;
	assign rdy_s1 = ~v_s1 | rdy_s2;
	assign q_pop  = q_stat.valid & rdy_s1;

	// Minimal wrapped difference between direction and previous direction.
	assign d_minus_p = $signed({2'b0, q_rec.dir}) - $signed({2'b0, q_rec.prev});
	assign up_d      = d_minus_p + $signed({2'b0, height});
	assign down_d    = d_minus_p - $signed({2'b0, height});
	assign abs_a     = d_minus_p[HGT_W+1] ? (HGT_W+2)'(0) - d_minus_p : d_minus_p;
	assign abs_u     = up_d[HGT_W+1] ? (HGT_W+2)'(0) - up_d : up_d;
	assign abs_d     = down_d[HGT_W+1] ? (HGT_W+2)'(0) - down_d : down_d;

	// A direction that went below zero counts as a huge unsigned value, so the
	// downward difference is the shortest and wraps in the same way.
	always_comb begin
		best = abs_a;
		if (abs_u < best) begin
			best = abs_u;
		end
		if (abs_d < best) begin
			best = abs_d;
		end
		if (q_rec.first) begin
			change = '0;
		end else if (q_rec.wrap) begin
			change = q_rec.dir - height - q_rec.prev;
		end else begin
			change = best[HGT_W-1:0];
		end
	end

	// Saturate a shifted product into the Q16 field.
	function automatic logic [NORM_W-1:0] sat_q16(input logic [PROD_W-1:0] p);
		logic [PROD_W-Q_SHIFT-1:0] q;
		begin
			q = p[PROD_W-1:Q_SHIFT];
			return (|q[PROD_W-Q_SHIFT-1:NORM_W]) ? '1 : q[NORM_W-1:0];
		end
	endfunction

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			gust_s1   <= q_rec.gust;
			speed_s1  <= q_rec.speed;
			dir_s1    <= q_rec.dir;
			change_s1 <= change;
			flags_s1  <= {q_rec.multiple, q_rec.seen, ~q_rec.first};
		end
		if (rdy_s2) begin
			gust_s2     <= gust_s1;
			speed_s2    <= speed_s1;
			dir_s2      <= dir_s1;
			change_s2   <= change_s1;
			flags_s2    <= flags_s1;
			gust_p_s2   <= PROD_W'(gust_s1) * PROD_W'(recip);
			speed_p_s2  <= PROD_W'(speed_s1) * PROD_W'(recip);
			dir_p_s2    <= PROD_W'(dir_s1) * PROD_W'(recip);
			change_p_s2 <= PROD_W'(change_s1) * PROD_W'(recip);
		end
		if (rdy_s3) begin
			data_s3 <= {sat_q16(change_p_s2), sat_q16(dir_p_s2), sat_q16(speed_p_s2),
			            sat_q16(gust_p_s2), change_s2, dir_s2, speed_s2, gust_s2};
			user_s3 <= flags_s2;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= q_stat.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = data_s3;
	assign m_tuser  = user_s3;

endmodule

[src/chart_column_trace_extractor.sv]
// Top level of the chart column trace extractor: config registers, front, queue, back.
// Throughput: one pixel per cycle while the column queue has room; a column result leaves
// through a four-entry queue. Path: a column's last pixel, once accepted, is written into
// the queue, then passes the change stage, multiply stage and output register on its way
// to the output. The input stalls only while the column queue is full.
// Reset (arst_n low) clears all column tracking, the queue, the pipeline and
// restores the register reset values.
module chart_column_trace_extractor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [chcte_pkg::PIX_W-1:0]      s_tdata,  // red, green, blue
	input  logic [0:0]                       s_tuser,  // image_start
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// gust_height, speed_height, direction_height, direction_change,
	// gust_norm, speed_norm, direction_norm, change_norm
	output logic [chcte_pkg::OUT_DATA_W-1:0] m_tdata,
	// change_valid, marker_found, marker_repeated
	output logic [chcte_pkg::OUT_USER_W-1:0] m_tuser,
	input  logic                             cfg_we,
	input  logic [chcte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [chcte_pkg::CFG_DATA_W-1:0] cfg_data
);
	import chcte_pkg::*;

	logic [HGT_W-1:0]   image_height_q;
	logic [RECIP_W-1:0] height_recip_q;
	logic [7:0]         marker_red_q, marker_green_q, marker_blue_q;
	logic [HGT_W-1:0]   height_eff;

	logic     col_push, q_pop;
	col_rec_t col_rec, q_rec;
	q_stat_t  q_stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_height_q <= HGT_W'(256);
			height_recip_q <= RECIP_W'(33'd16777216);
			marker_red_q   <= 8'd131;
			marker_green_q <= 8'd130;
			marker_blue_q  <= 8'd130;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HGT_W-1:0];
				REG_HEIGHT_RECIP: height_recip_q <= cfg_data[RECIP_W-1:0];
				REG_MARKER_RED:   marker_red_q   <= cfg_data[7:0];
				REG_MARKER_GREEN: marker_green_q <= cfg_data[7:0];
				REG_MARKER_BLUE:  marker_blue_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign height_eff = clamp_height(image_height_q);

	chcte_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.height       (height_eff),
		.marker_red   (marker_red_q),
		.marker_green (marker_green_q),
		.marker_blue  (marker_blue_q),
		.q_stat       (q_stat),
		.col_push     (col_push),
		.col_rec      (col_rec)
	);

	chcte_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (col_push),
		.push_rec (col_rec),
		.pop      (q_pop),
		.pop_rec  (q_rec),
		.stat     (q_stat)
	);

	chcte_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_rec    (q_rec),
		.q_pop    (q_pop),
		.height   (height_eff),
		.recip    (height_recip_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// A finished column is never pushed into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		col_push |-> !q_stat.full)
		else $error("column record pushed into a full queue");

	// The first column of an image reports no direction change.
	a_first_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |->
		(m_tdata[4*HGT_W-1:3*HGT_W] == '0 && m_tdata[OUT_DATA_W-1:OUT_DATA_W-NORM_W] == '0))
		else $error("first column carries a direction change");

	// A repeated marker implies a marker was found.
	a_repeat_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> m_tuser[1])
		else $error("marker repeat flagged without a marker");

endmodule
